### rtl/twsmc_pkg.sv
// Shared types, constants and helper functions for the two-wire sensor controller.
`default_nettype none
package twsmc_pkg;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_CLK_HI = 5'd1,
    PH_CLK_LO = 5'd2,
    PH_RTS    = 5'd3,
    PH_MTS    = 5'd4,
    PH_WR_LO  = 5'd5,
    PH_WR_HI  = 5'd6,
    PH_WA_LO  = 5'd7,
    PH_WA_HI  = 5'd8,
    PH_WAIT   = 5'd9,
    PH_RD_LO  = 5'd10,
    PH_RD_HI  = 5'd11,
    PH_RA_LO  = 5'd12,
    PH_RA_HI  = 5'd13,
    PH_FIN_M  = 5'd14,
    PH_FIN_R  = 5'd15
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_MEAS  = 2'd1,
    ACT_RESET = 2'd2
  } action_t;

  localparam logic [7:0]  CMD_TEMP      = 8'h03;
  localparam logic [7:0]  CMD_HUMID     = 8'h05;
  localparam logic [7:0]  SEED_TEMP     = 8'h53;
  localparam logic [7:0]  SEED_HUMID    = 8'hf5;
  localparam logic [7:0]  CRC_POLY      = 8'h31;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'hffff;
  localparam logic [3:0]  RESET_CLOCKS  = 4'd9;
  localparam logic [3:0]  START_STEPS   = 4'd7;
  localparam logic [3:0]  BYTE_BITS     = 4'd8;

  // Start condition waveform, one entry per sub-step (index 6 is the first step).
  localparam logic [6:0] START_DATA = 7'b1100011;
  localparam logic [6:0] START_SCK  = 7'b0110110;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic bit_in);
    logic fb;
    logic [7:0] nxt;
    fb  = bit_in ^ crc[7];
    nxt = {crc[6:0], 1'b0};
    if (fb) nxt = nxt ^ CRC_POLY;
    return nxt;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7 - k];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/two_wire_sensor_measure_controller.sv
// Top level of the two-wire sensor bus sequencer with measurement read and CRC check.
// A request's result is registered when the request is accepted and is valid from the next cycle.
// One request per cycle while the output is not stalled; the whole phase update is one registered step.
// The result register is refilled in the cycle it is taken, so a stalled output only
// holds off new requests while its own result is still waiting.
// Reset (synchronous, active low) returns the sequencer to idle, clears all counters,
// empties the result register and sets the wait limit to its maximum.
`default_nettype none
module two_wire_sensor_measure_controller (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_action,
  input  wire         in_mode,
  input  wire         in_data_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_sck,
  output logic        out_data_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_raw_value,
  output logic [7:0]  out_checksum_byte,
  output logic        out_crc_ok,
  output logic [1:0]  out_error_count
);

  twsmc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] value_r, value_nxt;
  logic [7:0]  check_r, check_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] wait_cnt_r, wait_cnt_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        mode_r, mode_nxt;
  logic [15:0] wait_limit_r;

  logic        out_valid_r;
  logic        sck_r, dout_r, busy_r, done_r, ok_r;
  logic [15:0] rv_r;
  logic [7:0]  cb_r;
  logic [1:0]  ec_r;

  logic        sck_c, dout_c, busy_c, done_c, ok_c;
  logic [15:0] rv_c;
  logic [7:0]  cb_c;
  logic [1:0]  ec_c;
  logic [15:0] lim;
  logic [2:0]  step;
  logic        accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign lim      = (wait_limit_r == 16'd0) ? 16'd1 : wait_limit_r;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_idx_nxt = byte_idx_r;
    shift_nxt    = shift_r;
    value_nxt    = value_r;
    check_nxt    = check_r;
    crc_nxt      = crc_r;
    wait_cnt_nxt = wait_cnt_r;
    err_nxt      = err_r;
    mode_nxt     = mode_r;
    sck_c  = 1'b0;
    dout_c = 1'b1;
    busy_c = 1'b1;
    done_c = 1'b0;
    ok_c   = 1'b0;
    rv_c   = 16'd0;
    cb_c   = 8'd0;
    ec_c   = 2'd0;
    step   = 3'd0;

    // A start request from idle also runs the first phase in the same request.
    if (phase_r == twsmc_pkg::PH_IDLE) begin
      if (in_action == twsmc_pkg::ACT_MEAS) begin
        mode_nxt     = in_mode;
        err_nxt      = 2'd0;
        value_nxt    = 16'd0;
        check_nxt    = 8'd0;
        crc_nxt      = in_mode ? twsmc_pkg::SEED_HUMID : twsmc_pkg::SEED_TEMP;
        shift_nxt    = in_mode ? twsmc_pkg::CMD_HUMID : twsmc_pkg::CMD_TEMP;
        bit_cnt_nxt  = 4'd0;
        byte_idx_nxt = 2'd0;
        wait_cnt_nxt = 16'd0;
        phase_nxt    = twsmc_pkg::PH_MTS;
      end else if (in_action == twsmc_pkg::ACT_RESET) begin
        bit_cnt_nxt = 4'd0;
        phase_nxt   = twsmc_pkg::PH_CLK_HI;
      end
    end

    case (phase_nxt)
      twsmc_pkg::PH_IDLE: begin
        busy_c = 1'b0;
      end
      twsmc_pkg::PH_CLK_HI: begin
        sck_c     = 1'b1;
        phase_nxt = twsmc_pkg::PH_CLK_LO;
      end
      twsmc_pkg::PH_CLK_LO: begin
        bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        if (bit_cnt_nxt >= twsmc_pkg::RESET_CLOCKS) begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = twsmc_pkg::PH_RTS;
        end else begin
          phase_nxt = twsmc_pkg::PH_CLK_HI;
        end
      end
      twsmc_pkg::PH_RTS, twsmc_pkg::PH_MTS: begin
        step   = (bit_cnt_nxt < twsmc_pkg::START_STEPS) ? bit_cnt_nxt[2:0] : 3'd6;
        sck_c  = twsmc_pkg::START_SCK[3'd6 - step];
        dout_c = twsmc_pkg::START_DATA[3'd6 - step];
        bit_cnt_nxt = {1'b0, step} + 4'd1;
        if (bit_cnt_nxt >= twsmc_pkg::START_STEPS) begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = (phase_nxt == twsmc_pkg::PH_RTS) ? twsmc_pkg::PH_FIN_R
                                                         : twsmc_pkg::PH_WR_LO;
        end
      end
      twsmc_pkg::PH_WR_LO: begin
        dout_c    = shift_nxt[7];
        phase_nxt = twsmc_pkg::PH_WR_HI;
      end
      twsmc_pkg::PH_WR_HI: begin
        sck_c       = 1'b1;
        dout_c      = shift_nxt[7];
        shift_nxt   = {shift_nxt[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        if (bit_cnt_nxt >= twsmc_pkg::BYTE_BITS) begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = twsmc_pkg::PH_WA_LO;
        end else begin
          phase_nxt = twsmc_pkg::PH_WR_LO;
        end
      end
      twsmc_pkg::PH_WA_LO: begin
        phase_nxt = twsmc_pkg::PH_WA_HI;
      end
      twsmc_pkg::PH_WA_HI: begin
        sck_c = 1'b1;
        if (in_data_in) err_nxt = err_nxt + 2'd1;
        wait_cnt_nxt = 16'd0;
        phase_nxt    = twsmc_pkg::PH_WAIT;
      end
      twsmc_pkg::PH_WAIT: begin
        if (!in_data_in) begin
          phase_nxt = twsmc_pkg::PH_RD_LO;
        end else begin
          wait_cnt_nxt = wait_cnt_nxt + 16'd1;
          // On timeout the read goes ahead anyway with one error counted.
          if (wait_cnt_nxt >= lim) begin
            err_nxt   = err_nxt + 2'd1;
            phase_nxt = twsmc_pkg::PH_RD_LO;
          end
        end
        if (phase_nxt == twsmc_pkg::PH_RD_LO) begin
          bit_cnt_nxt  = 4'd0;
          byte_idx_nxt = 2'd0;
          shift_nxt    = 8'd0;
        end
      end
      twsmc_pkg::PH_RD_LO: begin
        phase_nxt = twsmc_pkg::PH_RD_HI;
      end
      twsmc_pkg::PH_RD_HI: begin
        sck_c     = 1'b1;
        shift_nxt = {shift_nxt[6:0], in_data_in};
        if (byte_idx_nxt < 2'd2) crc_nxt = twsmc_pkg::crc_step(crc_nxt, in_data_in);
        bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        if (bit_cnt_nxt >= twsmc_pkg::BYTE_BITS) begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = twsmc_pkg::PH_RA_LO;
        end else begin
          phase_nxt = twsmc_pkg::PH_RD_LO;
        end
      end
      twsmc_pkg::PH_RA_LO: begin
        dout_c = (byte_idx_nxt < 2'd2) ? 1'b0 : 1'b1;
        if (byte_idx_nxt == 2'd0)      value_nxt = {shift_nxt, value_nxt[7:0]};
        else if (byte_idx_nxt == 2'd1) value_nxt = {value_nxt[15:8], shift_nxt};
        else                           check_nxt = shift_nxt;
        phase_nxt = twsmc_pkg::PH_RA_HI;
      end
      twsmc_pkg::PH_RA_HI: begin
        dout_c = (byte_idx_nxt < 2'd2) ? 1'b0 : 1'b1;
        sck_c  = 1'b1;
        if (byte_idx_nxt >= 2'd2) begin
          phase_nxt = twsmc_pkg::PH_FIN_M;
        end else begin
          byte_idx_nxt = byte_idx_nxt + 2'd1;
          bit_cnt_nxt  = 4'd0;
          shift_nxt    = 8'd0;
          phase_nxt    = twsmc_pkg::PH_RD_LO;
        end
      end
      twsmc_pkg::PH_FIN_M: begin
        ok_c = (twsmc_pkg::reverse8(crc_nxt) == check_nxt);
        if (!ok_c) err_nxt = err_nxt + 2'd1;
        rv_c      = value_nxt;
        cb_c      = check_nxt;
        ec_c      = err_nxt;
        busy_c    = 1'b0;
        done_c    = 1'b1;
        phase_nxt = twsmc_pkg::PH_IDLE;
      end
      twsmc_pkg::PH_FIN_R: begin
        busy_c    = 1'b0;
        done_c    = 1'b1;
        phase_nxt = twsmc_pkg::PH_IDLE;
      end
      default: begin
        busy_c    = 1'b0;
        phase_nxt = twsmc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= twsmc_pkg::PH_IDLE;
      bit_cnt_r    <= 4'd0;
      byte_idx_r   <= 2'd0;
      shift_r      <= 8'd0;
      value_r      <= 16'd0;
      check_r      <= 8'd0;
      crc_r        <= 8'd0;
      wait_cnt_r   <= 16'd0;
      err_r        <= 2'd0;
      mode_r       <= 1'b0;
      wait_limit_r <= twsmc_pkg::WAIT_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) wait_limit_r <= cfg_wr_data;
      if (accept) begin
        phase_r    <= phase_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        byte_idx_r <= byte_idx_nxt;
        shift_r    <= shift_nxt;
        value_r    <= value_nxt;
        check_r    <= check_nxt;
        crc_r      <= crc_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        err_r      <= err_nxt;
        mode_r     <= mode_nxt;
      end
      if (accept)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset; it is loaded with every accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      sck_r  <= sck_c;
      dout_r <= dout_c;
      busy_r <= busy_c;
      done_r <= done_c;
      ok_r   <= ok_c;
      rv_r   <= rv_c;
      cb_r   <= cb_c;
      ec_r   <= ec_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sck           = sck_r;
  assign out_data_out      = dout_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_raw_value     = rv_r;
  assign out_checksum_byte = cb_r;
  assign out_crc_ok        = ok_r;
  assign out_error_count   = ec_r;

endmodule
`default_nettype wire

### rtl/twsmc_checker.sv
// Port-level checker for the two-wire sensor controller and its bind statement.
`default_nettype none
module twsmc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_sck,
  input wire        out_data_out,
  input wire        out_busy_res,
  input wire        out_done_res,
  input wire [15:0] out_raw_value,
  input wire [7:0]  out_checksum_byte,
  input wire        out_crc_ok,
  input wire [1:0]  out_error_count
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_value)
      && $stable(out_error_count) && $stable(out_done_res))
    else $error("stalled result changed");

  // A waiting result that is not being taken must block new requests.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted over a stalled result");

  // An idle result drives the bus to its rest levels.
  a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res && !out_done_res |-> !out_sck && out_data_out)
    else $error("idle result does not rest the bus");

  // Measurement fields only appear on a finishing result.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_raw_value == 16'd0
      && out_checksum_byte == 8'd0 && !out_crc_ok && out_error_count == 2'd0)
    else $error("measurement fields set outside a finishing result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_wire_sensor_measure_controller twsmc_checker u_twsmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sck           (out_sck),
  .out_data_out      (out_data_out),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_raw_value     (out_raw_value),
  .out_checksum_byte (out_checksum_byte),
  .out_crc_ok        (out_crc_ok),
  .out_error_count   (out_error_count)
);
`default_nettype wire

### tb/two_wire_sensor_measure_controller_test.sv
// Self-checking testbench for the two-wire sensor bus sequencer, with a sensor-side stimulus model.
`timescale 1ns / 100ps
module two_wire_sensor_measure_controller_test;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic        MODE_TEMP   = 1'b0;
  localparam logic        MODE_HUMID  = 1'b1;
  localparam logic [7:0]  TEMP_CMD    = 8'h03;
  localparam logic [7:0]  HUMID_CMD   = 8'h05;
  localparam logic [7:0]  TEMP_SEED   = 8'h53;
  localparam logic [7:0]  HUMID_SEED  = 8'hf5;
  localparam logic [7:0]  CRC8_POLY   = 8'h31;
  localparam logic [15:0] LIMIT_MAX   = 16'hffff;
  // Start condition levels, bit s is sub-step s.
  localparam logic [6:0]  START_DATA_WAVE = 7'b1100011;
  localparam logic [6:0]  START_SCK_WAVE  = 7'b0110110;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic        sck;
    logic        data_out;
    logic        busy;
    logic        done;
    logic [15:0] raw_value;
    logic [7:0]  checksum_byte;
    logic        crc_ok;
    logic [1:0]  error_count;
  } bus_levels_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic        in_mode;
  logic        in_data_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_sck;
  logic        out_data_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [15:0] out_raw_value;
  logic [7:0]  out_checksum_byte;
  logic        out_crc_ok;
  logic [1:0]  out_error_count;

  two_wire_sensor_measure_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_mode          (in_mode),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sck          (out_sck),
    .out_data_out     (out_data_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_raw_value    (out_raw_value),
    .out_checksum_byte(out_checksum_byte),
    .out_crc_ok       (out_crc_ok),
    .out_error_count  (out_error_count)
  );

  always #6 clk = ~clk;

  // Sequencer state as the testbench expects it.
  twsmc_pkg::phase_t ph;
  logic [3:0]  bit_cnt;
  logic [1:0]  byte_idx;
  logic [7:0]  shreg;
  logic [15:0] value_q;
  logic [7:0]  chk_q;
  logic [7:0]  crc_q;
  logic [15:0] wait_cnt;
  logic [1:0]  err_sum;
  logic [15:0] wait_limit_q;

  // What the simulated sensor answers during the current sequence.
  logic [23:0] plan_word;
  logic        plan_ack;
  int unsigned plan_hold;
  logic        plan_noisy;

  bus_levels_t bus_levels_due[$];
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;
  int unsigned out_hold = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned measurements_run = 0;
  int unsigned flagged_measurements = 0;
  int unsigned resets_run = 0;
  int unsigned limit_writes = 0;

  function automatic logic [7:0] crc_shift(logic [7:0] crc, logic bit_in);
    logic fb;
    fb = bit_in ^ crc[7];
    crc = {crc[6:0], 1'b0};
    if (fb) crc = crc ^ CRC8_POLY;
    return crc;
  endfunction

  function automatic logic [7:0] flip_byte(logic [7:0] v);
    logic [7:0] r;
    r = {<<{v}};
    return r;
  endfunction

  function automatic void reset_bus_model();
    ph = twsmc_pkg::PH_IDLE;
    bit_cnt = '0;
    byte_idx = '0;
    shreg = '0;
    value_q = '0;
    chk_q = '0;
    crc_q = '0;
    wait_cnt = '0;
    err_sum = '0;
    wait_limit_q = LIMIT_MAX;
  endfunction

  // One tick of the sequencer: updates the expected state and returns the levels it drives.
  function automatic bus_levels_t advance_bus_phase(logic [1:0] act, logic md, logic din);
    bus_levels_t r;
    logic [15:0] lim;
    logic [2:0]  s;
    r = '0;
    r.data_out = 1'b1;
    r.busy = 1'b1;
    lim = (wait_limit_q == 16'd0) ? 16'd1 : wait_limit_q;
    if (ph == twsmc_pkg::PH_IDLE) begin
      if (act == twsmc_pkg::ACT_MEAS) begin
        err_sum = '0;
        value_q = '0;
        chk_q = '0;
        crc_q = (md == MODE_HUMID) ? HUMID_SEED : TEMP_SEED;
        shreg = (md == MODE_HUMID) ? HUMID_CMD : TEMP_CMD;
        bit_cnt = '0;
        byte_idx = '0;
        wait_cnt = '0;
        ph = twsmc_pkg::PH_MTS;
      end else if (act == twsmc_pkg::ACT_RESET) begin
        bit_cnt = '0;
        ph = twsmc_pkg::PH_CLK_HI;
      end
    end
    case (ph)
      twsmc_pkg::PH_IDLE: r.busy = 1'b0;
      twsmc_pkg::PH_CLK_HI: begin
        r.sck = 1'b1;
        ph = twsmc_pkg::PH_CLK_LO;
      end
      twsmc_pkg::PH_CLK_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd9) begin
          bit_cnt = '0;
          ph = twsmc_pkg::PH_RTS;
        end else begin
          ph = twsmc_pkg::PH_CLK_HI;
        end
      end
      twsmc_pkg::PH_RTS, twsmc_pkg::PH_MTS: begin
        s = (bit_cnt < 4'd7) ? bit_cnt[2:0] : 3'd6;
        r.sck = START_SCK_WAVE[s];
        r.data_out = START_DATA_WAVE[s];
        bit_cnt = {1'b0, s} + 4'd1;
        if (bit_cnt >= 4'd7) begin
          bit_cnt = '0;
          if (ph == twsmc_pkg::PH_RTS) ph = twsmc_pkg::PH_FIN_R;
          else ph = twsmc_pkg::PH_WR_LO;
        end
      end
      twsmc_pkg::PH_WR_LO: begin
        r.data_out = shreg[7];
        ph = twsmc_pkg::PH_WR_HI;
      end
      twsmc_pkg::PH_WR_HI: begin
        r.sck = 1'b1;
        r.data_out = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          ph = twsmc_pkg::PH_WA_LO;
        end else begin
          ph = twsmc_pkg::PH_WR_LO;
        end
      end
      twsmc_pkg::PH_WA_LO: ph = twsmc_pkg::PH_WA_HI;
      twsmc_pkg::PH_WA_HI: begin
        r.sck = 1'b1;
        if (din) err_sum = err_sum + 2'd1;
        wait_cnt = '0;
        ph = twsmc_pkg::PH_WAIT;
      end
      twsmc_pkg::PH_WAIT: begin
        if (!din) begin
          ph = twsmc_pkg::PH_RD_LO;
        end else begin
          wait_cnt = wait_cnt + 16'd1;
          // A timeout still moves on to the read.
          if (wait_cnt >= lim) begin
            err_sum = err_sum + 2'd1;
            ph = twsmc_pkg::PH_RD_LO;
          end
        end
        if (ph == twsmc_pkg::PH_RD_LO) begin
          bit_cnt = '0;
          byte_idx = '0;
          shreg = '0;
        end
      end
      twsmc_pkg::PH_RD_LO: ph = twsmc_pkg::PH_RD_HI;
      twsmc_pkg::PH_RD_HI: begin
        r.sck = 1'b1;
        shreg = {shreg[6:0], din};
        if (byte_idx < 2'd2) crc_q = crc_shift(crc_q, din);
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          ph = twsmc_pkg::PH_RA_LO;
        end else begin
          ph = twsmc_pkg::PH_RD_LO;
        end
      end
      twsmc_pkg::PH_RA_LO: begin
        r.data_out = (byte_idx < 2'd2) ? 1'b0 : 1'b1;
        if (byte_idx == 2'd0) value_q[15:8] = shreg;
        else if (byte_idx == 2'd1) value_q[7:0] = shreg;
        else chk_q = shreg;
        ph = twsmc_pkg::PH_RA_HI;
      end
      twsmc_pkg::PH_RA_HI: begin
        r.data_out = (byte_idx < 2'd2) ? 1'b0 : 1'b1;
        r.sck = 1'b1;
        if (byte_idx >= 2'd2) begin
          ph = twsmc_pkg::PH_FIN_M;
        end else begin
          byte_idx = byte_idx + 2'd1;
          bit_cnt = '0;
          shreg = '0;
          ph = twsmc_pkg::PH_RD_LO;
        end
      end
      twsmc_pkg::PH_FIN_M: begin
        r.crc_ok = (flip_byte(crc_q) == chk_q);
        if (!r.crc_ok) err_sum = err_sum + 2'd1;
        r.raw_value = value_q;
        r.checksum_byte = chk_q;
        r.error_count = err_sum;
        r.busy = 1'b0;
        r.done = 1'b1;
        ph = twsmc_pkg::PH_IDLE;
      end
      twsmc_pkg::PH_FIN_R: begin
        r.busy = 1'b0;
        r.done = 1'b1;
        ph = twsmc_pkg::PH_IDLE;
      end
      default: begin
        r.busy = 1'b0;
        ph = twsmc_pkg::PH_IDLE;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sensor_checksum(logic md, logic [15:0] value);
    logic [7:0] crc;
    crc = (md == MODE_HUMID) ? HUMID_SEED : TEMP_SEED;
    for (int i = 15; i >= 0; i--) crc = crc_shift(crc, value[i]);
    return flip_byte(crc);
  endfunction

  // DATA level the sensor presents for the next tick, given where the sequencer stands.
  function automatic logic sensor_level();
    logic       lvl;
    logic [4:0] pos;
    lvl = 1'($urandom_range(0, 1));
    pos = 5'd23 - {byte_idx, 3'b000} - {1'b0, bit_cnt};
    if (!plan_noisy) begin
      case (ph)
        twsmc_pkg::PH_WA_HI: lvl = !plan_ack;
        twsmc_pkg::PH_WAIT:  lvl = (wait_cnt >= plan_hold) ? 1'b0 : 1'b1;
        twsmc_pkg::PH_RD_HI: lvl = plan_word[pos];
        default:  ;
      endcase
    end
    return lvl;
  endfunction

  // Mostly plain ticks; now and then a random action, possibly a start of either kind, which a busy sequencer ignores.
  function automatic logic [1:0] noise_action();
    logic [1:0] act;
    act = twsmc_pkg::ACT_TICK;
    if ($urandom_range(0, 9) == 0) act = 2'($urandom_range(0, 3));
    return act;
  endfunction

  task automatic note_failure(string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] seen);
    if (want !== seen)
      note_failure($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                             results_checked, field, want, seen));
  endtask

  task automatic send_request(logic [1:0] act, logic md, logic din);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_mode <= md;
    in_data_in <= din;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bus_levels_due.push_back(advance_bus_phase(act, md, din));
    requests_sent++;
  endtask

  task automatic finish_sequence();
    while (ph != twsmc_pkg::PH_IDLE)
      send_request(noise_action(), 1'($urandom_range(0, 1)), sensor_level());
  endtask

  task automatic write_wait_limit(logic [15:0] lim);
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_levels_due.size() != 0) @(negedge clk);
    cfg_wr_data <= lim;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    wait_limit_q = lim;
    limit_writes++;
  endtask

  task automatic run_measurement(logic md, logic [15:0] value, bit good_crc, bit acked,
                                 int unsigned hold, bit noisy);
    logic [7:0] chk;
    chk = sensor_checksum(md, value);
    if (!good_crc) chk = chk ^ 8'($urandom_range(1, 255));
    plan_word = {value, chk};
    plan_ack = acked;
    plan_hold = hold;
    plan_noisy = noisy;
    send_request(twsmc_pkg::ACT_MEAS, md, 1'($urandom_range(0, 1)));
    finish_sequence();
    measurements_run++;
  endtask

  task automatic run_conn_reset();
    plan_noisy = 1'b1;
    send_request(twsmc_pkg::ACT_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    finish_sequence();
    resets_run++;
  endtask

  task automatic test_idle_ticks();
    send_request(twsmc_pkg::ACT_TICK, MODE_TEMP, 1'b0);
    send_request(ACT_UNUSED, MODE_HUMID, 1'b1);
    send_request(twsmc_pkg::ACT_TICK, MODE_HUMID, 1'b1);
    send_request(ACT_UNUSED, MODE_TEMP, 1'b0);
  endtask

  task automatic test_connection_reset();
    run_conn_reset();
  endtask

  // Runs at the wait limit left by reset.
  task automatic test_clean_measurements();
    run_measurement(MODE_TEMP, 16'h0000, 1'b1, 1'b1, 0, 1'b0);
    run_measurement(MODE_HUMID, 16'hffff, 1'b1, 1'b1, 5, 1'b0);
  endtask

  task automatic test_error_paths();
    // A zero limit acts as one tick, so any delay times out.
    write_wait_limit(16'd0);
    run_measurement(MODE_TEMP, 16'h8001, 1'b0, 1'b0, 3, 1'b0);
    write_wait_limit(16'd1);
    run_measurement(MODE_HUMID, 16'h1234, 1'b1, 1'b1, 0, 1'b0);
    run_measurement(MODE_TEMP, 16'h4321, 1'b1, 1'b0, 1, 1'b0);
    write_wait_limit(16'd50);
    run_measurement(MODE_HUMID, 16'h00ff, 1'b0, 1'b1, 49, 1'b0);
    run_measurement(MODE_TEMP, 16'hff00, 1'b1, 1'b1, 50, 1'b0);
  endtask

  // A long wait that runs out a large limit; idling is off to keep the run short.
  task automatic test_longest_wait();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    write_wait_limit(16'd400);
    run_measurement(MODE_HUMID, 16'h5aa5, 1'b1, 1'b1, 400, 1'b0);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned kind;
    int unsigned hold;
    logic [15:0] lim;
    stop_at = requests_sent + 900;
    while (requests_sent < stop_at) begin
      in_gaps_on = ($urandom_range(0, 4) != 0);
      out_stalls_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 5))
          0: lim = 16'd0;
          1: lim = 16'd1;
          2: lim = LIMIT_MAX;
          3: lim = 16'($urandom_range(0, 65535));
          default: lim = 16'($urandom_range(2, 40));
        endcase
        write_wait_limit(lim);
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 4);
        run_measurement(1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(0, 6) != 0,
                        $urandom_range(0, 7) != 0, hold, 1'b0);
      end else if (kind < 70) begin
        run_conn_reset();
      end else if (kind < 80) begin
        run_measurement(1'($urandom_range(0, 1)), 16'($urandom), 1'b0, 1'b0, 0, 1'b1);
      end else begin
        // Random requests from idle; whatever they start is run out with random DATA.
        plan_noisy = 1'b1;
        repeat ($urandom_range(1, 5))
          send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        finish_sequence();
      end
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // A new stall length is drawn after every result taken.
  always @(negedge clk) begin
    if (results_checked != results_seen) begin
      results_seen = results_checked;
      out_hold = out_stalls_on ? $urandom_range(0, 9) : 0;
    end
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bus_levels_t seen;
    bus_levels_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_sck, out_data_out, out_busy_res, out_done_res, out_raw_value,
              out_checksum_byte, out_crc_ok, out_error_count};
      if (bus_levels_due.size() == 0) begin
        note_failure($sformatf("result with no request outstanding: 0x%0h", seen));
      end else begin
        want = bus_levels_due.pop_front();
        compare_field("sck", 16'(want.sck), 16'(seen.sck));
        compare_field("data_out", 16'(want.data_out), 16'(seen.data_out));
        compare_field("busy_res", 16'(want.busy), 16'(seen.busy));
        compare_field("done_res", 16'(want.done), 16'(seen.done));
        compare_field("raw_value", want.raw_value, seen.raw_value);
        compare_field("checksum_byte", 16'(want.checksum_byte), 16'(seen.checksum_byte));
        compare_field("crc_ok", 16'(want.crc_ok), 16'(seen.crc_ok));
        compare_field("error_count", 16'(want.error_count), 16'(seen.error_count));
        if (want.done && want.error_count != 2'd0) flagged_measurements++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, bus_levels_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_action = twsmc_pkg::ACT_TICK;
    in_mode = MODE_TEMP;
    in_data_in = 1'b0;
    plan_word = '0;
    plan_ack = 1'b1;
    plan_hold = 0;
    plan_noisy = 1'b1;
    reset_bus_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_connection_reset();
    test_clean_measurements();
    test_error_paths();
    test_longest_wait();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d measurements (%0d with errors),",
             requests_sent, results_checked, measurements_run, flagged_measurements);
    $display("%0d connection resets, %0d wait limit writes; %0d mismatches.",
             resets_run, limit_writes, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
